>>> hdl/circular_linked_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Circular linked list engine assertion macros
// Shared concurrent assertion forms for the engine's RTL modules.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LINKED_LIST_ENGINE_ASSERT_SVH
`define CIRCULAR_LINKED_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CLLE_CHECK(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define CLLE_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/clle_pkg.sv
// ----------------------------------------------------------------------------
// Circular linked list engine package
// Field widths, command and status codes shared by the engine modules.
// ----------------------------------------------------------------------------
package clle_pkg;

   localparam int POOL_NODES_DEF = 64;
   localparam int VAL_W          = 32;
   localparam int LEN_W          = 7;
   localparam int CMD_W          = 2;
   localparam int STAT_W         = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT   = 2'd0,
      CMD_DELETE   = 2'd1,
      CMD_TRAVERSE = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_type;

endpackage

>>> hdl/circular_linked_list_engine.sv
// ----------------------------------------------------------------------------
// Circular linked list engine
// Circular singly linked list in a fixed node pool with insert-after-key,
// delete-key and traverse commands.
//
//   channel | ports | direction | word
//   --------+-------+-----------+------------------------------------------
//   request | req_  | in        | command, search_key, new_value
//   result  | rsp_  | out       | status, element, list_length, last
//
// One word at a time. The walk follows links through the node store's single
// read port, one node per cycle. Result stalls hold the walk; the request
// channel stalls until the current word's last result is registered.
// Reset is synchronous and leaves the list empty; no memory clearing pass.
// ----------------------------------------------------------------------------
module circular_linked_list_engine #(
   parameter int POOL_NODES = clle_pkg::POOL_NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [clle_pkg::CMD_W-1:0]        req_command,
   input  logic signed [clle_pkg::VAL_W-1:0] req_search_key,
   input  logic signed [clle_pkg::VAL_W-1:0] req_new_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [clle_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [clle_pkg::VAL_W-1:0] rsp_element,
   output logic [clle_pkg::LEN_W-1:0]        rsp_list_length,
   output logic                              rsp_last
);

   localparam int IDX_W = $clog2(POOL_NODES);

   logic                       rd_en;
   logic [IDX_W-1:0]           rd_addr;
   logic [clle_pkg::VAL_W-1:0] rd_value;
   logic [IDX_W-1:0]           rd_link;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [clle_pkg::VAL_W-1:0] wr_value;
   logic [IDX_W-1:0]           wr_link;
   logic                       alloc_req;
   logic [IDX_W-1:0]           alloc_idx;
   logic                       free_req;
   logic [IDX_W-1:0]           free_idx;

   // node store
   clle_store #(
      .POOL_NODES (POOL_NODES)
   ) u_store (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_link  (rd_link),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_value (wr_value),
      .wr_link  (wr_link)
   );

   // free node allocator
   clle_alloc #(
      .POOL_NODES (POOL_NODES)
   ) u_alloc (
      .clock     (clock),
      .reset     (reset),
      .alloc_req (alloc_req),
      .alloc_idx (alloc_idx),
      .free_req  (free_req),
      .free_idx  (free_idx)
   );

   // command sequencer
   clle_ctrl #(
      .POOL_NODES (POOL_NODES)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_search_key  (req_search_key),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_list_length (rsp_list_length),
      .rsp_last        (rsp_last),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_value        (rd_value),
      .rd_link         (rd_link),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_value        (wr_value),
      .wr_link         (wr_link),
      .alloc_req       (alloc_req),
      .alloc_idx       (alloc_idx),
      .free_req        (free_req),
      .free_idx        (free_idx)
   );

endmodule

>>> hdl/clle_store.sv
// ----------------------------------------------------------------------------
// Node store
// Single-port-write, single-port-read memory of {value, link} node words,
// read data registered, held while no read is issued.
// ----------------------------------------------------------------------------
module clle_store #(
   parameter int  POOL_NODES = clle_pkg::POOL_NODES_DEF,
   localparam int IDX_W      = $clog2(POOL_NODES)
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [IDX_W-1:0]           rd_addr,
   output logic [clle_pkg::VAL_W-1:0] rd_value,
   output logic [IDX_W-1:0]           rd_link,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [clle_pkg::VAL_W-1:0] wr_value,
   input  logic [IDX_W-1:0]           wr_link
);

   localparam int WORD_W = clle_pkg::VAL_W + IDX_W;

   logic [WORD_W-1:0] mem [POOL_NODES];
   logic [WORD_W-1:0] rd_word_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_value, wr_link};
      end
   end

   // read port, data registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
      end
   end

   assign rd_value = rd_word_ff[WORD_W-1:IDX_W];
   assign rd_link  = rd_word_ff[IDX_W-1:0];

endmodule

>>> hdl/clle_alloc.sv
// ----------------------------------------------------------------------------
// Node allocator
// Hands out free node indexes: a high-water counter covers nodes never used,
// a stack memory holds nodes that were freed. Index valid the cycle after
// the request.
// ----------------------------------------------------------------------------
`include "circular_linked_list_engine_assert.svh"

module clle_alloc #(
   parameter int  POOL_NODES = clle_pkg::POOL_NODES_DEF,
   localparam int IDX_W      = $clog2(POOL_NODES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             alloc_req,
   output logic [IDX_W-1:0] alloc_idx,
   input  logic             free_req,
   input  logic [IDX_W-1:0] free_idx
);

   localparam int                CNT_W    = $clog2(POOL_NODES + 1);
   localparam logic [CNT_W-1:0]  POOL_CNT = CNT_W'(POOL_NODES);

   logic [IDX_W-1:0] stack [POOL_NODES];
   logic [CNT_W-1:0] sp_ff;
   logic [CNT_W-1:0] hw_ff;
   logic             pop_ff;
   logic [IDX_W-1:0] stack_q_ff;
   logic [IDX_W-1:0] hw_idx_ff;
   logic [CNT_W-1:0] sp_dec;
   logic             can_alloc;

   assign sp_dec    = sp_ff - 1'b1;
   assign can_alloc = (sp_ff != '0) || (hw_ff != POOL_CNT);

   // freed-node stack memory
   always_ff @(posedge clock) begin
      if (free_req) begin
         stack[sp_ff[IDX_W-1:0]] <= free_idx;
      end
      if (alloc_req && (sp_ff != '0)) begin
         stack_q_ff <= stack[sp_dec[IDX_W-1:0]];
      end
      if (alloc_req && (sp_ff == '0)) begin
         hw_idx_ff <= hw_ff[IDX_W-1:0];
      end
   end

   // stack pointer and high-water mark
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff  <= '0;
         hw_ff  <= '0;
         pop_ff <= 1'b0;
      end else begin
         if (alloc_req) begin
            pop_ff <= (sp_ff != '0);
            if (sp_ff != '0) begin
               sp_ff <= sp_dec;
            end else begin
               hw_ff <= hw_ff + 1'b1;
            end
         end else if (free_req) begin
            sp_ff <= sp_ff + 1'b1;
         end
      end
   end

   assign alloc_idx = pop_ff ? stack_q_ff : hw_idx_ff;

   `CLLE_CHECK(a_no_alloc_free, clock, reset, alloc_req, !free_req, "alloc and free together")
   `CLLE_CHECK(a_alloc_avail, clock, reset, alloc_req, can_alloc, "alloc from empty pool")
   `CLLE_CHECK(a_free_room, clock, reset, free_req, sp_ff < hw_ff, "free stack overrun")

endmodule

>>> hdl/clle_ctrl.sv
// ----------------------------------------------------------------------------
// List sequencer
// Walks nodes one per cycle for insert, delete and traverse (result stalls
// hold traverse), keeps tail and count, drives the registered result word.
// ----------------------------------------------------------------------------
`include "circular_linked_list_engine_assert.svh"

module clle_ctrl #(
   parameter int  POOL_NODES = clle_pkg::POOL_NODES_DEF,
   localparam int IDX_W      = $clog2(POOL_NODES)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [clle_pkg::CMD_W-1:0]         req_command,
   input  logic signed [clle_pkg::VAL_W-1:0]  req_search_key,
   input  logic signed [clle_pkg::VAL_W-1:0]  req_new_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [clle_pkg::STAT_W-1:0]        rsp_status,
   output logic signed [clle_pkg::VAL_W-1:0]  rsp_element,
   output logic [clle_pkg::LEN_W-1:0]         rsp_list_length,
   output logic                               rsp_last,
   output logic                               rd_en,
   output logic [IDX_W-1:0]                   rd_addr,
   input  logic [clle_pkg::VAL_W-1:0]         rd_value,
   input  logic [IDX_W-1:0]                   rd_link,
   output logic                               wr_en,
   output logic [IDX_W-1:0]                   wr_addr,
   output logic [clle_pkg::VAL_W-1:0]         wr_value,
   output logic [IDX_W-1:0]                   wr_link,
   output logic                               alloc_req,
   input  logic [IDX_W-1:0]                   alloc_idx,
   output logic                               free_req,
   output logic [IDX_W-1:0]                   free_idx
);

   localparam int               CNT_W    = $clog2(POOL_NODES + 1);
   localparam logic [CNT_W-1:0] POOL_CNT = CNT_W'(POOL_NODES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIRST,
      S_WALK,
      S_INS_NEW,
      S_INS_LINK,
      S_PRED,
      S_TRAV,
      S_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic                         is_insert_ff, is_insert_in;
   logic [clle_pkg::VAL_W-1:0]   key_ff, key_in;
   logic [clle_pkg::VAL_W-1:0]   val_ff, val_in;
   logic [IDX_W-1:0]             tail_ff, tail_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]             cur_ff, cur_in;
   logic [IDX_W-1:0]             prev_ff, prev_in;
   logic [clle_pkg::VAL_W-1:0]   prev_value_ff, prev_value_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [clle_pkg::VAL_W-1:0]   hit_value_ff, hit_value_in;
   logic [IDX_W-1:0]             hit_link_ff, hit_link_in;
   logic [IDX_W-1:0]             fresh_ff, fresh_in;
   clle_pkg::status_type         status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   clle_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [clle_pkg::VAL_W-1:0]   rsp_element_ff, rsp_element_in;
   logic [CNT_W-1:0]             rsp_length_ff, rsp_length_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         slot_free;
   logic                         match;
   logic [CNT_W-1:0]             n_next;
   logic                         final_node;
   logic                         walking;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign match      = (rd_value == key_ff);
   assign n_next     = n_ff + 1'b1;
   assign final_node = (n_next == count_ff);
   assign walking    = (state_ff == S_WALK) || (state_ff == S_TRAV);

   // next-state and memory port decode
   always_comb begin
      state_in       = state_ff;
      is_insert_in   = is_insert_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      prev_value_in  = prev_value_ff;
      n_in           = n_ff;
      hit_value_in   = hit_value_ff;
      hit_link_in    = hit_link_ff;
      fresh_in       = fresh_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_last_in    = rsp_last_ff;
      rd_en          = 1'b0;
      rd_addr        = cur_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_value       = val_ff;
      wr_link        = hit_link_ff;
      alloc_req      = 1'b0;
      free_req       = 1'b0;
      free_idx       = cur_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               is_insert_in = (clle_pkg::cmd_type'(req_command) == clle_pkg::CMD_INSERT);
               key_in       = req_search_key;
               val_in       = req_new_value;
               cur_in       = tail_ff;
               n_in         = '0;
               status_in    = clle_pkg::STAT_OK;
               case (clle_pkg::cmd_type'(req_command))
                  clle_pkg::CMD_INSERT: begin
                     if (count_ff == POOL_CNT) begin
                        status_in = clle_pkg::STAT_FULL;
                        state_in  = S_DONE;
                     end else if (count_ff == '0) begin
                        alloc_req = 1'b1;
                        state_in  = S_FIRST;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = tail_ff;
                        state_in = S_WALK;
                     end
                  end
                  clle_pkg::CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = clle_pkg::STAT_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = tail_ff;
                        state_in = S_WALK;
                     end
                  end
                  clle_pkg::CMD_TRAVERSE: begin
                     if (count_ff == '0) begin
                        status_in = clle_pkg::STAT_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = tail_ff;
                        state_in = S_TRAV;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // first node of an empty list links to itself
         S_FIRST: begin
            wr_en    = 1'b1;
            wr_addr  = alloc_idx;
            wr_value = val_ff;
            wr_link  = alloc_idx;
            tail_in  = alloc_idx;
            count_in = CNT_W'(1);
            state_in = S_DONE;
         end

         // search from the tail, one node per cycle
         S_WALK: begin
            if (match) begin
               if (is_insert_ff) begin
                  hit_value_in = rd_value;
                  hit_link_in  = rd_link;
                  alloc_req    = 1'b1;
                  state_in     = S_INS_NEW;
               end else if (count_ff == CNT_W'(1)) begin
                  free_req = 1'b1;
                  free_idx = cur_ff;
                  tail_in  = '0;
                  count_in = '0;
                  state_in = S_DONE;
               end else if (n_ff == '0) begin
                  // tail hit: find its predecessor
                  hit_link_in = rd_link;
                  cur_in      = rd_link;
                  rd_en       = 1'b1;
                  rd_addr     = rd_link;
                  state_in    = S_PRED;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = prev_ff;
                  wr_value = prev_value_ff;
                  wr_link  = rd_link;
                  free_req = 1'b1;
                  free_idx = cur_ff;
                  count_in = count_ff - 1'b1;
                  state_in = S_DONE;
               end
            end else if (final_node) begin
               status_in = clle_pkg::STAT_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               prev_in       = cur_ff;
               prev_value_in = rd_value;
               cur_in        = rd_link;
               n_in          = n_next;
               rd_en         = 1'b1;
               rd_addr       = rd_link;
            end
         end

         // new node takes the hit node's successor
         S_INS_NEW: begin
            wr_en    = 1'b1;
            wr_addr  = alloc_idx;
            wr_value = val_ff;
            wr_link  = hit_link_ff;
            fresh_in = alloc_idx;
            state_in = S_INS_LINK;
         end

         // hit node now points at the new node
         S_INS_LINK: begin
            wr_en    = 1'b1;
            wr_addr  = cur_ff;
            wr_value = hit_value_ff;
            wr_link  = fresh_ff;
            count_in = count_ff + 1'b1;
            state_in = S_DONE;
         end

         // walk to the node that links to the tail, then unlink the tail
         S_PRED: begin
            if (rd_link == tail_ff) begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff;
               wr_value = rd_value;
               wr_link  = hit_link_ff;
               free_req = 1'b1;
               free_idx = tail_ff;
               tail_in  = hit_link_ff;
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               cur_in  = rd_link;
               rd_en   = 1'b1;
               rd_addr = rd_link;
            end
         end

         // one result word per node; read data holds while stalled
         S_TRAV: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = clle_pkg::STAT_OK;
               rsp_element_in = rd_value;
               rsp_length_in  = count_ff;
               rsp_last_in    = final_node;
               if (final_node) begin
                  state_in = S_IDLE;
               end else begin
                  n_in    = n_next;
                  cur_in  = rd_link;
                  rd_en   = 1'b1;
                  rd_addr = rd_link;
               end
            end
         end

         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_element_in = '0;
               rsp_length_in  = count_ff;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      is_insert_ff   <= is_insert_in;
      key_ff         <= key_in;
      val_ff         <= val_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      prev_value_ff  <= prev_value_in;
      n_ff           <= n_in;
      hit_value_ff   <= hit_value_in;
      hit_link_ff    <= hit_link_in;
      fresh_ff       <= fresh_in;
      status_ff      <= status_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_length_ff  <= rsp_length_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_element     = rsp_element_ff;
   assign rsp_list_length = clle_pkg::LEN_W'(rsp_length_ff);
   assign rsp_last        = rsp_last_ff;

   `CLLE_CHECK(a_count_range, clock, reset, 1'b1, count_ff <= POOL_CNT, "count above pool size")
   `CLLE_CHECK(a_empty_tail, clock, reset, count_ff == '0, tail_ff == '0, "tail set on empty list")
   `CLLE_CHECK(a_walk_bound, clock, reset, walking, n_ff < count_ff, "walk ran past list length")
   `CLLE_CHECK_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall, "idle after accept")

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// Circular linked list engine testbench
// Drives insert, delete, traverse and unknown command words into the engine.
// Every result word is checked against a behavioral copy of the list kept
// here. A short directed table comes first, then random phases with random
// idling on both channels. The random phases are: mixed, pool fill up to full,
// delete-heavy drain, and mixed again.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import clle_pkg::*;

   localparam int                POOL        = POOL_NODES_DEF;
   localparam logic [CMD_W-1:0]  CMD_UNKNOWN = 2'd3;
   localparam int                IDLE_PCT    = 22;
   localparam int                STALL_LIMIT = 4000;
   localparam int                DRAIN_WAIT  = 2 * POOL + 16;
   localparam int                RANDOM_WORDS = 460;

   // one result word as the engine reports it
   typedef struct packed {
      status_type         status;
      logic [VAL_W-1:0]   element;
      logic [LEN_W-1:0]   length;
      logic               last;
   } rsp_word_type;

   // one row of the directed table
   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [VAL_W-1:0]   key;
      logic [VAL_W-1:0]   val;
      bit                 typed;
      rsp_word_type       word;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CMD_W-1:0]         req_command = '0;
   logic signed [VAL_W-1:0]  req_search_key = '0;
   logic signed [VAL_W-1:0]  req_new_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [VAL_W-1:0]  rsp_element;
   logic [LEN_W-1:0]         rsp_list_length;
   logic                     rsp_last;

   // shadow copy of the node pool
   logic [VAL_W-1:0]   pool_value [POOL];
   logic [5:0]         pool_link  [POOL];
   bit                 pool_used  [POOL];
   logic [5:0]         tail_node;
   logic [LEN_W-1:0]   live_count;

   rsp_word_type  pending_results [$];
   stim_row_type  directed_rows [$];
   rsp_word_type  head_word;
   bit            steady = 1'b0;
   int unsigned   fail_count = 0;
   int unsigned   words_sent = 0;
   int unsigned   results_checked = 0;
   int unsigned   random_items = 0;
   int unsigned   full_rejects = 0;
   int unsigned   peak_length = 0;
   int unsigned   quiet_cycles = 0;

   circular_linked_list_engine #(.POOL_NODES(POOL)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_search_key  (req_search_key),
      .req_new_value   (req_new_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_element     (rsp_element),
      .rsp_list_length (rsp_list_length),
      .rsp_last        (rsp_last)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_word_type make_word(status_type st, logic [VAL_W-1:0] elem,
                                              logic [LEN_W-1:0] len, logic last);
      rsp_word_type w;
      w.status  = st;
      w.element = elem;
      w.length  = len;
      w.last    = last;
      return w;
   endfunction

   // apply one command to the shadow list and queue the words it produces
   function automatic void list_apply(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] key,
                                      logic [VAL_W-1:0] val);
      int          fresh;
      logic [5:0]  cur;
      logic [5:0]  prev;
      bit          found;
      status_type  st;
      fresh = -1;
      cur   = tail_node;
      prev  = tail_node;
      found = 1'b0;
      st    = STAT_OK;
      case (cmd)
         CMD_INSERT: begin
            for (int i = 0; i < POOL; i++)
               if (fresh < 0 && !pool_used[i]) fresh = i;
            if (fresh < 0) begin
               st = STAT_FULL;
            end else if (live_count == 0) begin
               // empty list: key ignored, node links to itself
               pool_value[fresh] = val;
               pool_link[fresh]  = 6'(fresh);
               pool_used[fresh]  = 1'b1;
               tail_node         = 6'(fresh);
               live_count        = 1;
            end else begin
               for (int n = 0; n < live_count; n++)
                  if (!found) begin
                     if (pool_value[cur] == key) found = 1'b1;
                     else cur = pool_link[cur];
                  end
               if (found) begin
                  pool_value[fresh] = val;
                  pool_link[fresh]  = pool_link[cur];
                  pool_link[cur]    = 6'(fresh);
                  pool_used[fresh]  = 1'b1;
                  live_count        = live_count + 1;
               end else begin
                  st = STAT_NOT_FOUND;
               end
            end
            pending_results.push_back(make_word(st, '0, live_count, 1'b1));
         end
         CMD_DELETE: begin
            if (live_count == 0) begin
               st = STAT_EMPTY;
            end else begin
               for (int n = 0; n < live_count; n++)
                  if (!found) begin
                     if (pool_value[cur] == key) begin
                        found = 1'b1;
                     end else begin
                        prev = cur;
                        cur  = pool_link[cur];
                     end
                  end
               if (!found) begin
                  st = STAT_NOT_FOUND;
               end else if (live_count == 1) begin
                  // last node gone, tail back to zero
                  pool_used[cur] = 1'b0;
                  tail_node      = '0;
                  live_count     = 0;
               end else begin
                  // removing the tail: find its predecessor, successor takes over
                  if (cur == tail_node) begin
                     prev = tail_node;
                     for (int n = 0; n + 1 < live_count; n++) prev = pool_link[prev];
                     tail_node = pool_link[tail_node];
                  end
                  pool_link[prev] = pool_link[cur];
                  pool_used[cur]  = 1'b0;
                  live_count      = live_count - 1;
               end
            end
            pending_results.push_back(make_word(st, '0, live_count, 1'b1));
         end
         CMD_TRAVERSE: begin
            if (live_count == 0) begin
               pending_results.push_back(make_word(STAT_EMPTY, '0, '0, 1'b1));
            end else begin
               for (int n = 0; n < live_count; n++) begin
                  pending_results.push_back(make_word(STAT_OK, pool_value[cur], live_count,
                                                      n + 1 == live_count));
                  cur = pool_link[cur];
               end
            end
         end
         default: pending_results.push_back(make_word(STAT_OK, '0, live_count, 1'b1));
      endcase
      if (st == STAT_FULL) full_rejects++;
      if (live_count > peak_length) peak_length = live_count;
   endfunction

   function automatic void add_row(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] key,
                                   logic [VAL_W-1:0] val, bit typed = 1'b0,
                                   status_type st = STAT_OK, logic [LEN_W-1:0] len = '0);
      stim_row_type row;
      row.cmd   = cmd;
      row.key   = key;
      row.val   = val;
      row.typed = typed;
      row.word  = make_word(st, '0, len, 1'b1);
      directed_rows.push_back(row);
   endfunction

   // key mostly taken from a live node, sometimes arbitrary
   function automatic logic [VAL_W-1:0] pick_key();
      logic [5:0]  cur;
      int          steps;
      cur = tail_node;
      if (live_count == 0 || $urandom_range(99) < 20) return $urandom;
      steps = $urandom_range(live_count - 1);
      for (int n = 0; n < steps; n++) cur = pool_link[cur];
      return pool_value[cur];
   endfunction

   // values lean on extremes now and then, which also makes duplicates
   function automatic logic [VAL_W-1:0] pick_value();
      if ($urandom_range(99) >= 30) return $urandom;
      case ($urandom_range(4))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFF;
         3: return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   // present one word, wait for acceptance, then predict its results
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] key,
                            logic [VAL_W-1:0] val, bit typed, rsp_word_type typed_word);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_search_key <= key;
      req_new_value  <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      list_apply(cmd, key, val);
      // typed rows carry their own expected word
      if (typed) begin
         void'(pending_results.pop_back());
         pending_results.push_back(typed_word);
      end
      words_sent++;
   endtask

   task automatic send_random(int ins_pct, int del_pct, int trav_pct);
      int                r;
      logic [CMD_W-1:0]  cmd;
      r = $urandom_range(99);
      if (r < ins_pct) cmd = CMD_INSERT;
      else if (r < ins_pct + del_pct) cmd = CMD_DELETE;
      else if (r < ins_pct + del_pct + trav_pct) cmd = CMD_TRAVERSE;
      else cmd = CMD_UNKNOWN;
      send_word(cmd, pick_key(), pick_value(), 1'b0, '0);
      random_items++;
   endtask

   // hold off the sender until every pending word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      @(posedge clock);
   endtask

   function automatic void check_field(string name, logic [VAL_W-1:0] exp_val,
                                       logic [VAL_W-1:0] act_val);
      if (act_val !== exp_val) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name,
                  exp_val, act_val);
      end
   endfunction

   // result side stall
   always @(posedge clock) begin
      if (reset || steady) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < IDLE_PCT);
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            $display("%0t ns: unexpected word, expected none, actual %h %h %h %h",
                     $time, rsp_status, rsp_element, rsp_list_length, rsp_last);
         end else begin
            head_word = pending_results.pop_front();
            check_field("status", VAL_W'(head_word.status), VAL_W'(rsp_status));
            check_field("element", head_word.element, rsp_element);
            check_field("list_length", VAL_W'(head_word.length), VAL_W'(rsp_list_length));
            check_field("last", VAL_W'(head_word.last), VAL_W'(rsp_last));
            results_checked++;
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles, %0d words pending", $time,
                  STALL_LIMIT, pending_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // stimulus
   initial begin
      tail_node  = '0;
      live_count = '0;
      foreach (pool_used[i]) begin
         pool_used[i]  = 1'b0;
         pool_value[i] = '0;
         pool_link[i]  = '0;
      end

      // empty list cases
      add_row(CMD_TRAVERSE, 32'h0, 32'h0, 1'b1, STAT_EMPTY, 0);
      add_row(CMD_DELETE, 32'h0, 32'h0, 1'b1, STAT_EMPTY, 0);
      add_row(CMD_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STAT_OK, 0);
      // first insert ignores the key
      add_row(CMD_INSERT, 32'h0001_2345, 32'h8000_0000, 1'b1, STAT_OK, 1);
      // absent key on a single node
      add_row(CMD_DELETE, 32'h5, 32'h0, 1'b1, STAT_NOT_FOUND, 1);
      add_row(CMD_INSERT, 32'h7, 32'h9, 1'b1, STAT_NOT_FOUND, 1);
      // grow with extremes
      add_row(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, STAT_OK, 2);
      add_row(CMD_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, STAT_OK, 3);
      add_row(CMD_INSERT, 32'h8000_0000, 32'h0, 1'b1, STAT_OK, 4);
      add_row(CMD_TRAVERSE, 32'h0, 32'h0);
      // tail removal moves the tail
      add_row(CMD_DELETE, 32'h8000_0000, 32'h0, 1'b1, STAT_OK, 3);
      add_row(CMD_TRAVERSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_row(CMD_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b1, STAT_OK, 2);
      // duplicate values, freed node reused
      add_row(CMD_INSERT, 32'h0, 32'h0, 1'b1, STAT_OK, 3);
      add_row(CMD_DELETE, 32'h0, 32'h0, 1'b1, STAT_OK, 2);
      add_row(CMD_TRAVERSE, 32'h0, 32'h0);
      add_row(CMD_UNKNOWN, 32'h0, 32'h0);
      add_row(CMD_DELETE, 32'h7FFF_FFFF, 32'h0, 1'b1, STAT_OK, 1);
      add_row(CMD_TRAVERSE, 32'h0, 32'h0);
      // only node removed
      add_row(CMD_DELETE, 32'h0, 32'h0, 1'b1, STAT_OK, 0);
      add_row(CMD_TRAVERSE, 32'h0, 32'h0, 1'b1, STAT_EMPTY, 0);
      add_row(CMD_INSERT, 32'h7FFF_FFFF, 32'h55AA_55AA);
      add_row(CMD_TRAVERSE, 32'h0, 32'h0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].val,
                   directed_rows[i].typed, directed_rows[i].word);

      // mixed traffic
      repeat (150) send_random(45, 35, 15);
      drain_results();

      // fill the pool, then push against the full pool
      while (live_count < POOL) send_random(100, 0, 0);
      repeat (6) send_random(100, 0, 0);
      send_word(CMD_TRAVERSE, $urandom, $urandom, 1'b0, '0);
      random_items++;

      // drain-heavy traffic
      repeat (120) send_random(20, 65, 10);
      drain_results();

      // mixed traffic, first stretch without any idling
      steady = 1'b1;
      repeat (100) send_random(45, 35, 15);
      steady = 1'b0;
      while (random_items < RANDOM_WORDS) send_random(45, 35, 15);

      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Covered %0d request words and %0d result words;",
               words_sent, results_checked);
      $display("peak length %0d, %0d full-pool rejects.", peak_length, full_rejects);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
